// ===== rtl/core/otsl_pkg.sv =====
// Shared types and constants for the one-shot timer list unit.
// Depends on nothing; every module of the unit imports it.
`default_nettype none

package otsl_pkg;

   // Default number of timer slots in the cell chain.
   localparam int NUM_SLOTS_DEFAULT = 16;

   // Request codes.
   localparam logic REQ_REGISTER = 1'b0;
   localparam logic REQ_ELAPSED  = 1'b1;

   // Result kinds.
   localparam logic [1:0] KIND_REGISTERED = 2'd0;
   localparam logic [1:0] KIND_REJECTED   = 2'd1;
   localparam logic [1:0] KIND_EXPIRED    = 2'd2;
   localparam logic [1:0] KIND_SUMMARY    = 2'd3;

   // Input transaction payload.
   typedef struct packed {
      logic        req_type;
      logic [15:0] timer_tag;
      logic [31:0] delay_us;
      logic [31:0] elapsed_us;
   } req_payload_type;

   // Result transaction payload.
   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] fired_tag;
      logic [31:0] next_left_us;
      logic        any_pending;
      logic        last;
   } rsp_payload_type;

   // One timer held by a cell.
   typedef struct packed {
      logic [15:0] tag;
      logic [31:0] remaining;
   } entry_type;

   // Control broadcast from the sequencer to every cell.
   typedef struct packed {
      logic append;
      logic step;
      logic fire;
   } cell_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/core/otsl_cell.sv =====
// One slot of the timer chain: a used flag and one timer entry.
// Depends on otsl_pkg for the entry and control types.
`default_nettype none

module otsl_cell (
   input  wire                    clock,
   input  wire                    reset,
   input  otsl_pkg::cell_ctl_type ctl,
   input  otsl_pkg::entry_type    new_entry,
   input  otsl_pkg::entry_type    survivor,
   input  wire                    prev_used,
   input  wire                    next_used,
   input  otsl_pkg::entry_type    next_entry,
   output logic                   used,
   output otsl_pkg::entry_type    entry
);
   import otsl_pkg::*;

   logic      used_ff;
   logic      used_in;
   entry_type entry_ff;
   entry_type entry_in;

   // Append fills the first free cell; a step shifts the chain toward the head,
   // and the last used cell takes back the surviving head entry.
   always_comb begin
      used_in  = used_ff;
      entry_in = entry_ff;
      if (ctl.append && !used_ff && prev_used) begin
         used_in  = 1'b1;
         entry_in = new_entry;
      end else if (ctl.step) begin
         entry_in = next_entry;
         if (ctl.fire) begin
            used_in = next_used;
         end else if (used_ff && !next_used) begin
            entry_in = survivor;
         end
      end
   end

   // Only the used flag is control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign used  = used_ff;
   assign entry = entry_ff;

endmodule

`default_nettype wire

// ===== rtl/core/one_shot_timer_list_unit.sv =====
// One-shot timer list: a chain of NUM_SLOTS cells in arrival order.
// Register transaction: its one result is in the output register the cycle after acceptance.
// Elapsed transaction: while the output is not stalled, the chain passes one entry by the head
// cell per cycle and expirations leave one per cycle; the summary follows once all have passed.
// Throughput without output stalls: one register transaction per cycle; no new transaction is
// accepted until an elapsed pass has issued its summary. Reset (synchronous) empties every slot.
`default_nettype none

module one_shot_timer_list_unit #(
   parameter int NUM_SLOTS = otsl_pkg::NUM_SLOTS_DEFAULT
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_stall,
   input  otsl_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   output otsl_pkg::rsp_payload_type rsp_payload
);
   import otsl_pkg::*;

   localparam int CNT_W = $clog2(NUM_SLOTS + 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic             state_ff;
   logic             state_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CNT_W-1:0] steps_ff;
   logic [CNT_W-1:0] steps_in;
   logic [31:0]      elapsed_ff;
   logic [31:0]      elapsed_in;
   logic [31:0]      min_ff;
   logic [31:0]      min_in;
   logic             first_ff;
   logic             first_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   rsp_payload_type  rsp_data_ff;
   rsp_payload_type  rsp_data_in;

   logic             used_vec [NUM_SLOTS];
   entry_type        entry_vec [NUM_SLOTS];
   cell_ctl_type     ctl;
   entry_type        new_entry;
   entry_type        survivor;
   entry_type        head;
   logic             out_free;
   logic             req_accept;
   logic             is_register;
   logic             full;
   logic             step;
   logic             summary;
   logic             fire;
   logic [31:0]      reg_min;

   assign head        = entry_vec[0];
   assign full        = used_vec[NUM_SLOTS-1];
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign req_stall   = (state_ff != ST_IDLE) || !out_free;
   assign req_accept  = req_valid && !req_stall;
   assign is_register = (req_payload.req_type == REQ_REGISTER);
   assign step        = (state_ff == ST_RUN) && out_free && (steps_ff != '0);
   assign summary     = (state_ff == ST_RUN) && out_free && (steps_ff == '0);
   assign fire        = elapsed_ff > head.remaining;

   assign new_entry.tag       = req_payload.timer_tag;
   assign new_entry.remaining = req_payload.delay_us;
   assign survivor.tag        = head.tag;
   assign survivor.remaining  = head.remaining - elapsed_ff;

   assign ctl.append = req_accept && is_register && !full;
   assign ctl.step   = step;
   assign ctl.fire   = fire;

   // Smallest remaining time once a register transaction is applied.
   always_comb begin
      reg_min = min_ff;
      if (!full) begin
         if (count_ff == '0 || req_payload.delay_us < min_ff) begin
            reg_min = req_payload.delay_us;
         end
      end
   end

   // Row of cells; each one shifts toward the head during an elapsed pass.
   for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
      logic      prev_used;
      logic      next_used;
      entry_type next_entry;
      if (i == 0) begin : g_head
         assign prev_used = 1'b1;
      end else begin : g_body
         assign prev_used = used_vec[i-1];
      end
      if (i == NUM_SLOTS - 1) begin : g_tail
         assign next_used  = 1'b0;
         assign next_entry = survivor;
      end else begin : g_inner
         assign next_used  = used_vec[i+1];
         assign next_entry = entry_vec[i+1];
      end
      otsl_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .new_entry  (new_entry),
         .survivor   (survivor),
         .prev_used  (prev_used),
         .next_used  (next_used),
         .next_entry (next_entry),
         .used       (used_vec[i]),
         .entry      (entry_vec[i])
      );
   end

   // Sequencer, pending count and running minimum.
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      steps_in   = steps_ff;
      elapsed_in = elapsed_ff;
      min_in     = min_ff;
      first_in   = first_ff;
      if (req_accept) begin
         if (is_register) begin
            min_in = reg_min;
            if (!full) begin
               count_in = count_ff + 1'b1;
            end
         end else begin
            state_in   = ST_RUN;
            steps_in   = count_ff;
            elapsed_in = req_payload.elapsed_us;
            first_in   = 1'b1;
         end
      end
      if (step) begin
         steps_in = steps_ff - 1'b1;
         if (fire) begin
            count_in = count_ff - 1'b1;
         end else begin
            first_in = 1'b0;
            if (first_ff || survivor.remaining < min_ff) begin
               min_in = survivor.remaining;
            end
         end
      end
      if (summary) begin
         state_in = ST_IDLE;
      end
   end

   // Output register with the results of each transaction.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (req_accept && is_register) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.kind         = full ? KIND_REJECTED : KIND_REGISTERED;
         rsp_data_in.fired_tag    = '0;
         rsp_data_in.next_left_us = reg_min;
         rsp_data_in.any_pending  = 1'b1;
         rsp_data_in.last         = 1'b1;
      end else if (step && fire) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.kind         = KIND_EXPIRED;
         rsp_data_in.fired_tag    = head.tag;
         rsp_data_in.next_left_us = '0;
         rsp_data_in.any_pending  = 1'b0;
         rsp_data_in.last         = 1'b0;
      end else if (summary) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.kind         = KIND_SUMMARY;
         rsp_data_in.fired_tag    = '0;
         rsp_data_in.next_left_us = (count_ff != '0) ? min_ff : '0;
         rsp_data_in.any_pending  = (count_ff != '0);
         rsp_data_in.last         = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         steps_ff     <= '0;
         first_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         steps_ff     <= steps_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      elapsed_ff  <= elapsed_in;
      min_ff      <= min_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

`default_nettype wire
